### rtl/hrd_pkg.sv
// Package for the haversine route distance block: beat types, fixed-point
// constants, the arctangent table and the rounding helper.
// No dependencies.
`default_nettype none
package hrd_pkg;

   localparam int TOTAL_BITS_DEF   = 48;
   localparam int CORDIC_STEPS_DEF = 32;
   localparam int DW               = 36;
   localparam int PW               = 2 * DW;

   localparam logic [23:0] RADIUS_RESET = 24'd6371000;

   localparam logic signed [DW-1:0] Q30_ONE     = 36'sd1073741824;
   localparam logic signed [DW-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [DW-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [DW-1:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [DW-1:0] CORDIC_GAIN = 36'sd652032874;
   localparam logic signed [DW-1:0] DEG_TO_RAD  = 36'sd503056907;
   localparam logic [34:0]          SEG_MAX     = 35'h7_FFFF_FFFF;

   typedef struct packed {
      logic signed [30:0] lat_e7;
      logic signed [31:0] lon_e7;
      logic               start_route;
   } req_type;

   typedef struct packed {
      logic [34:0] segment_mm;
      logic [47:0] total_mm;
      logic        total_saturated;
   } rsp_type;

   function automatic logic [31:0] atan_q30(input logic [5:0] idx);
      logic [31:0] r;
      case (idx)
         6'd0:    r = 32'd843314857;
         6'd1:    r = 32'd497837829;
         6'd2:    r = 32'd263043837;
         6'd3:    r = 32'd133525159;
         6'd4:    r = 32'd67021687;
         6'd5:    r = 32'd33543516;
         6'd6:    r = 32'd16775851;
         6'd7:    r = 32'd8388437;
         6'd8:    r = 32'd4194283;
         6'd9:    r = 32'd2097149;
         6'd10:   r = 32'd1048576;
         6'd11:   r = 32'd524288;
         6'd12:   r = 32'd262144;
         6'd13:   r = 32'd131072;
         6'd14:   r = 32'd65536;
         6'd15:   r = 32'd32768;
         6'd16:   r = 32'd16384;
         6'd17:   r = 32'd8192;
         6'd18:   r = 32'd4096;
         6'd19:   r = 32'd2048;
         6'd20:   r = 32'd1024;
         6'd21:   r = 32'd512;
         6'd22:   r = 32'd256;
         6'd23:   r = 32'd128;
         6'd24:   r = 32'd64;
         6'd25:   r = 32'd32;
         6'd26:   r = 32'd16;
         6'd27:   r = 32'd8;
         6'd28:   r = 32'd4;
         6'd29:   r = 32'd2;
         6'd30:   r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   // Divides by a power of two, rounding half away from zero.
   function automatic logic signed [PW-1:0] rnd_shift(input logic signed [PW-1:0] v,
                                                      input int unsigned s);
      logic [PW-1:0] m;
      m = v[PW-1] ? PW'(-v) : PW'(v);
      m = (m + (PW'(1) << (s - 1))) >> s;
      return v[PW-1] ? -$signed(m) : $signed(m);
   endfunction

endpackage
`default_nettype wire

### rtl/haversine_route_distance.sv
// Top level of the haversine route distance block: sequencer, shared CORDIC,
// root and multiplier datapath, running total and result register.
// Depends on hrd_pkg.
//
//  channel   direction  handshake        beat
//  req_      in         valid / stall    hrd_pkg::req_type point
//  rsp_      out        valid / stall    hrd_pkg::rsp_type segment and total
//  csr_      in         valid / ready    earth radius in metres, 24 bits
//
// A point that follows another point of its route is worked through in order: range reduction
// and rotation of each of the four CORDIC arguments, the products, the two square roots, the
// vectoring, the scaling to millimetres and the result. The pace is set by the one CORDIC stage
// and the one root stage, which are stepped once a cycle; no new point is taken meanwhile.
// A route start or a first point goes straight to the result.
// Reset is synchronous; it clears the route state and loads the default radius.
// A stalled result holds; the next point is taken while it waits.
`default_nettype none
module haversine_route_distance #(
   parameter int TOTAL_BITS   = hrd_pkg::TOTAL_BITS_DEF,
   parameter int CORDIC_STEPS = hrd_pkg::CORDIC_STEPS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  hrd_pkg::req_type      req_payload,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output hrd_pkg::rsp_type      rsp_payload,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [23:0]           csr_data
);

   localparam int DW  = hrd_pkg::DW;
   localparam int PW  = hrd_pkg::PW;
   localparam int ITW = $clog2(CORDIC_STEPS);
   localparam int CW  = (ITW > 5) ? ITW : 5;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ANG, ST_RND, ST_RED, ST_ROT, ST_SAVE,
      ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_SQ, ST_VEC, ST_SCALE, ST_MM, ST_DONE
   } state_type;

   state_type               state_ff;
   logic [1:0]              op_ff;
   logic [CW-1:0]           cnt_ff;
   logic                    flip_ff;
   logic                    sq_sel_ff;
   logic signed [30:0]      prev_lat_ff, cur_lat_ff;
   logic signed [31:0]      prev_lon_ff, cur_lon_ff;
   logic                    cur_start_ff;
   logic                    have_prev_ff;
   logic [TOTAL_BITS-1:0]   total_ff;
   logic [23:0]             radius_ff;
   logic signed [DW-1:0]    x_ff, y_ff, z_ff;
   logic signed [DW-1:0]    s1_ff, s2_ff, c1_ff, c2_ff, cc_ff, t_ff, u_ff, a_ff;
   logic signed [DW-1:0]    ysq_ff;
   logic signed [PW-1:0]    prod_ff;
   logic [63:0]             v_ff, r_ff, bit_ff;
   logic [34:0]             seg_ff;
   logic                    rsp_valid_ff;
   hrd_pkg::rsp_type        rsp_ff;

   logic signed [DW-1:0]    mul_a, mul_b;
   logic signed [DW-1:0]    xs, ys, at;
   logic                    sigma;
   logic signed [DW-1:0]    x_in, y_in, z_in;
   logic [63:0]             trial;
   logic                    ge;
   logic signed [DW-1:0]    a_sum;
   logic signed [DW-1:0]    a_clamp;
   logic signed [DW-1:0]    ang;
   logic [PW-1:0]           mm_wide;
   logic [PW-1:0]           mm_rnd;
   logic [TOTAL_BITS-1:0]   headroom;
   logic [TOTAL_BITS-1:0]   total_in;
   logic                    out_free;
   logic                    load_rsp;

   assign req_stall   = (state_ff != ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign load_rsp    = (state_ff == ST_DONE) && out_free;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_ANG: begin
            mul_b = hrd_pkg::DEG_TO_RAD;
            unique case (op_ff)
               2'd0:    mul_a = DW'(cur_lat_ff) - DW'(prev_lat_ff);
               2'd1:    mul_a = DW'(cur_lon_ff) - DW'(prev_lon_ff);
               2'd2:    mul_a = DW'(prev_lat_ff);
               default: mul_a = DW'(cur_lat_ff);
            endcase
         end
         ST_M1:    begin mul_a = c1_ff; mul_b = c2_ff; end
         ST_M2:    begin mul_a = s2_ff; mul_b = s2_ff; end
         ST_M3:    begin mul_a = s1_ff; mul_b = s1_ff; end
         ST_M4:    begin mul_a = cc_ff; mul_b = t_ff;  end
         ST_SCALE: begin mul_a = ang;   mul_b = $signed({12'd0, radius_ff}); end
         default:  begin mul_a = '0;    mul_b = '0;    end
      endcase
   end

   always_comb begin
      xs    = x_ff >>> cnt_ff;
      ys    = y_ff >>> cnt_ff;
      at    = $signed({4'd0, hrd_pkg::atan_q30(6'(cnt_ff))});
      sigma = (state_ff == ST_VEC) ? y_ff[DW-1] : !z_ff[DW-1];
      if (sigma) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + at;
      end
      trial   = r_ff + bit_ff;
      ge      = (v_ff >= trial);
      a_sum   = u_ff + DW'(hrd_pkg::rnd_shift(prod_ff, 30));
      a_clamp = a_sum[DW-1] ? '0 : ((a_sum > hrd_pkg::Q30_ONE) ? hrd_pkg::Q30_ONE : a_sum);
      ang     = z_ff[DW-1] ? '0 : (z_ff <<< 1);
      mm_wide = (PW'(prod_ff) << 10) - (PW'(prod_ff) << 5) + (PW'(prod_ff) << 3);
      mm_rnd  = (mm_wide + (PW'(1) << 29)) >> 30;
      headroom = TOTAL_MAX - total_ff;
      if (cur_start_ff)
         total_in = '0;
      else if ({30'd0, seg_ff} > 65'(headroom))
         total_in = TOTAL_MAX;
      else
         total_in = total_ff + TOTAL_BITS'(seg_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         total_ff     <= '0;
         prev_lat_ff  <= '0;
         prev_lon_ff  <= '0;
         radius_ff    <= hrd_pkg::RADIUS_RESET;
         op_ff        <= '0;
         cnt_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready)
            radius_ff <= csr_data;
         if (load_rsp)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cur_lat_ff   <= req_payload.lat_e7;
                  cur_lon_ff   <= req_payload.lon_e7;
                  cur_start_ff <= req_payload.start_route;
                  seg_ff       <= '0;
                  op_ff        <= '0;
                  if (req_payload.start_route || !have_prev_ff)
                     state_ff <= ST_DONE;
                  else
                     state_ff <= ST_ANG;
               end
            end
            ST_ANG: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= ST_RND;
            end
            ST_RND: begin
               z_ff     <= DW'(hrd_pkg::rnd_shift(prod_ff, (op_ff[1] ? 28 : 29)));
               state_ff <= ST_RED;
            end
            ST_RED: begin
               if (z_ff > hrd_pkg::Q30_PI) begin
                  z_ff <= z_ff - hrd_pkg::Q30_TWO_PI;
               end else if (z_ff < -hrd_pkg::Q30_PI) begin
                  z_ff <= z_ff + hrd_pkg::Q30_TWO_PI;
               end else begin
                  if (z_ff > hrd_pkg::Q30_HALF_PI) begin
                     z_ff    <= z_ff - hrd_pkg::Q30_PI;
                     flip_ff <= 1'b1;
                  end else if (z_ff < -hrd_pkg::Q30_HALF_PI) begin
                     z_ff    <= z_ff + hrd_pkg::Q30_PI;
                     flip_ff <= 1'b1;
                  end else begin
                     flip_ff <= 1'b0;
                  end
                  x_ff     <= hrd_pkg::CORDIC_GAIN;
                  y_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_ROT;
               end
            end
            ST_ROT: begin
               x_ff   <= x_in;
               y_ff   <= y_in;
               z_ff   <= z_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(CORDIC_STEPS - 1))
                  state_ff <= ST_SAVE;
            end
            ST_SAVE: begin
               unique case (op_ff)
                  2'd0:    s1_ff <= flip_ff ? -y_ff : y_ff;
                  2'd1:    s2_ff <= flip_ff ? -y_ff : y_ff;
                  2'd2:    c1_ff <= flip_ff ? -x_ff : x_ff;
                  default: c2_ff <= flip_ff ? -x_ff : x_ff;
               endcase
               op_ff    <= op_ff + 1'b1;
               state_ff <= (op_ff == 2'd3) ? ST_M1 : ST_ANG;
            end
            ST_M1: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= ST_M2;
            end
            ST_M2: begin
               cc_ff    <= DW'(hrd_pkg::rnd_shift(prod_ff, 30));
               prod_ff  <= mul_a * mul_b;
               state_ff <= ST_M3;
            end
            ST_M3: begin
               t_ff     <= DW'(hrd_pkg::rnd_shift(prod_ff, 30));
               prod_ff  <= mul_a * mul_b;
               state_ff <= ST_M4;
            end
            ST_M4: begin
               u_ff     <= DW'(hrd_pkg::rnd_shift(prod_ff, 30));
               prod_ff  <= mul_a * mul_b;
               state_ff <= ST_M5;
            end
            ST_M5: begin
               a_ff      <= a_clamp;
               v_ff      <= 64'(a_clamp) << 30;
               r_ff      <= '0;
               bit_ff    <= 64'd1 << 62;
               cnt_ff    <= '0;
               sq_sel_ff <= 1'b0;
               state_ff  <= ST_SQ;
            end
            ST_SQ: begin
               if (cnt_ff == CW'(31)) begin
                  cnt_ff <= '0;
                  if (!sq_sel_ff) begin
                     ysq_ff    <= DW'(ge ? (r_ff >> 1) + bit_ff : r_ff >> 1);
                     v_ff      <= 64'(hrd_pkg::Q30_ONE - a_ff) << 30;
                     r_ff      <= '0;
                     bit_ff    <= 64'd1 << 62;
                     sq_sel_ff <= 1'b1;
                  end else begin
                     x_ff     <= DW'(ge ? (r_ff >> 1) + bit_ff : r_ff >> 1);
                     y_ff     <= ysq_ff;
                     z_ff     <= '0;
                     state_ff <= ST_VEC;
                  end
               end else begin
                  if (ge) begin
                     v_ff <= v_ff - trial;
                     r_ff <= (r_ff >> 1) + bit_ff;
                  end else begin
                     r_ff <= r_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_VEC: begin
               x_ff   <= x_in;
               y_ff   <= y_in;
               z_ff   <= z_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(CORDIC_STEPS - 1))
                  state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               prod_ff  <= mul_a * mul_b;
               state_ff <= ST_MM;
            end
            ST_MM: begin
               seg_ff   <= (mm_rnd > PW'(hrd_pkg::SEG_MAX)) ? hrd_pkg::SEG_MAX : 35'(mm_rnd);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  total_ff                <= total_in;
                  prev_lat_ff             <= cur_lat_ff;
                  prev_lon_ff             <= cur_lon_ff;
                  have_prev_ff            <= 1'b1;
                  rsp_ff.segment_mm       <= seg_ff;
                  rsp_ff.total_mm         <= 48'(total_in);
                  rsp_ff.total_saturated  <= (total_in == TOTAL_MAX);
                  state_ff                <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_clamp_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ) |-> (a_ff >= 0 && a_ff <= hrd_pkg::Q30_ONE))
      else $error("haversine term outside its range");

   start_is_short: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.start_route) |=> (state_ff == ST_DONE))
      else $error("route start did not go straight to the result");

   flag_matches_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.total_saturated) |-> (total_ff == TOTAL_MAX))
      else $error("saturation flag without a full total");

   busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT || state_ff == ST_SQ || state_ff == ST_VEC) |-> req_stall)
      else $error("point taken while the datapath is busy");

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for haversine_route_distance: drives route points and
// radius writes, predicts each segment and running total, and checks every beat.
// Depends on hrd_pkg and the haversine_route_distance RTL.
`timescale 1ns / 100ps
module testbench;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint GAIN_Q30    = 64'sd652032874;
   localparam longint E7_TO_RAD   = 64'sd503056907;
   localparam longint unsigned SEG_LIMIT   = 64'd34359738367;
   localparam longint unsigned TOTAL_LIMIT = 64'hFFFF_FFFF_FFFF;
   localparam int STEPS       = 32;
   localparam int STALL_LIMIT = 5000;
   localparam int MAX_RADIUS  = 16777215;

   typedef struct {
      int  lat;
      int  lon;
      bit  start;
      bit  typed;
      longint unsigned seg;
      longint unsigned total;
      bit  sat;
   } point_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   hrd_pkg::req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   hrd_pkg::rsp_type rsp_payload;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [23:0] csr_data = '0;

   hrd_pkg::rsp_type pending_legs[$];
   int      error_count = 0;
   int      quiet_cycles = 0;
   int      stall_left = 0;
   bit      idling = 1'b1;

   longint          last_lat = 0;
   longint          last_lon = 0;
   bit              have_last = 1'b0;
   longint unsigned route_sum = 0;
   longint unsigned radius_m = 6371000;

   longint atan_lut[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
      32, 16, 8, 4, 2, 1, 0};

   haversine_route_distance uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint rnd_div(longint v, int s);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void sin_cos(longint z, output longint sn, output longint cs);
      longint x;
      longint y;
      longint nx;
      bit     flip;
      x = GAIN_Q30;
      y = 0;
      flip = 1'b0;
      while (z > PI_Q30) z = z - TWO_PI_Q30;
      while (z < -PI_Q30) z = z + TWO_PI_Q30;
      if (z > HALF_PI_Q30) begin
         z = z - PI_Q30;
         flip = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         z = z + PI_Q30;
         flip = 1'b1;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - atan_lut[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + atan_lut[i];
         end
         x = nx;
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z;
      longint nx;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + atan_lut[i];
         end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - atan_lut[i];
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic longint unsigned leg_mm(longint lat1, longint lon1,
                                              longint lat2, longint lon2);
      longint s1, s2, c1, c2, unused, a, cc, ang;
      longint unsigned d, mm;
      sin_cos(rnd_div((lat2 - lat1) * E7_TO_RAD, 29), s1, unused);
      sin_cos(rnd_div((lon2 - lon1) * E7_TO_RAD, 29), s2, unused);
      sin_cos(rnd_div(lat1 * E7_TO_RAD, 28), unused, c1);
      sin_cos(rnd_div(lat2 * E7_TO_RAD, 28), unused, c2);
      cc = rnd_div(c1 * c2, 30);
      a = rnd_div(s1 * s1, 30) + rnd_div(cc * rnd_div(s2 * s2, 30), 30);
      if (a < 0) a = 0;
      if (a > ONE_Q30) a = ONE_Q30;
      ang = 2 * vector_angle(longint'(int_root(longint'(a) << 30)),
                             longint'(int_root(longint'(ONE_Q30 - a) << 30)));
      if (ang < 0) ang = 0;
      d = longint'(ang) * radius_m;
      mm = (d >> 30) * 1000 + (((d & 64'h3FFF_FFFF) * 1000 + (64'd1 << 29)) >> 30);
      return (mm > SEG_LIMIT) ? SEG_LIMIT : mm;
   endfunction

   function automatic hrd_pkg::rsp_type advance_route(hrd_pkg::req_type p);
      hrd_pkg::rsp_type r;
      longint unsigned  seg;
      seg = 0;
      if (p.start_route) begin
         route_sum = 0;
      end else if (have_last) begin
         seg = leg_mm(last_lat, last_lon, longint'(p.lat_e7), longint'(p.lon_e7));
         if (route_sum > TOTAL_LIMIT || seg > TOTAL_LIMIT - route_sum) route_sum = TOTAL_LIMIT;
         else route_sum = route_sum + seg;
      end
      last_lat = longint'(p.lat_e7);
      last_lon = longint'(p.lon_e7);
      have_last = 1'b1;
      r.segment_mm = seg[34:0];
      r.total_mm = route_sum[47:0];
      r.total_saturated = (route_sum == TOTAL_LIMIT);
      return r;
   endfunction

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      int n;
      if (!reset && rsp_valid && !rsp_stall) begin
         n = idling ? $urandom_range(0, 16) : 0;
         if (pending_legs.size() == 0) begin
            $error("result beat with no expectation waiting");
            error_count++;
         end else begin
            hrd_pkg::rsp_type e;
            e = pending_legs.pop_front();
            if (e.segment_mm !== rsp_payload.segment_mm) begin
               $error("segment_mm: expected %0d, got %0d", e.segment_mm, rsp_payload.segment_mm);
               error_count++;
            end
            if (e.total_mm !== rsp_payload.total_mm) begin
               $error("total_mm: expected %0d, got %0d", e.total_mm, rsp_payload.total_mm);
               error_count++;
            end
            if (e.total_saturated !== rsp_payload.total_saturated) begin
               $error("total_saturated: expected %0d, got %0d",
                      e.total_saturated, rsp_payload.total_saturated);
               error_count++;
            end
         end
      end else begin
         n = stall_left;
      end
      if (n > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= n - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end
   end

   task automatic send_point(hrd_pkg::req_type p, bit typed, hrd_pkg::rsp_type typed_rsp);
      int               gap;
      hrd_pkg::rsp_type e;
      gap = idling ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      e = advance_route(p);
      pending_legs.push_back(typed ? typed_rsp : e);
   endtask

   task automatic write_radius(logic [23:0] r);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_legs.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= r;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      radius_m = r;
   endtask

   function automatic hrd_pkg::req_type random_point();
      hrd_pkg::req_type p;
      int               pick;
      pick = $urandom_range(0, 99);
      p.start_route = ($urandom_range(0, 99) < 5);
      if (pick < 50) begin
         p.lat_e7 = 31'(last_lat + $signed($urandom_range(0, 200000)) - 100000);
         p.lon_e7 = 32'(last_lon + $signed($urandom_range(0, 200000)) - 100000);
      end else if (pick < 85) begin
         p.lat_e7 = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
         p.lon_e7 = 32'(longint'($urandom_range(0, 3600000000)) - 1800000000);
      end else begin
         p.lat_e7 = 31'($urandom);
         p.lon_e7 = 32'($urandom);
      end
      return p;
   endfunction

   task automatic random_run(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) idling = ($urandom_range(0, 3) != 0);
         send_point(random_point(), 1'b0, '0);
      end
   endtask

   point_row_type plan[] = '{
      '{0, 0, 0, 1, 0, 0, 0},
      '{900000000, 1800000000, 0, 0, 0, 0, 0},
      '{-900000000, -1800000000, 0, 0, 0, 0, 0},
      '{-900000000, -1800000000, 0, 0, 0, 0, 0},
      '{0, 0, 1, 1, 0, 0, 0},
      '{0, 1800000000, 0, 0, 0, 0, 0},
      '{1073741823, 2147483647, 0, 0, 0, 0, 0},
      '{-1073741824, -2147483648, 0, 0, 0, 0, 0},
      '{1073741823, -2147483648, 1, 1, 0, 0, 0},
      '{-1073741824, 2147483647, 0, 0, 0, 0, 0},
      '{1, 1, 0, 0, 0, 0, 0},
      '{2, -1, 0, 0, 0, 0, 0},
      '{515000000, -1270000, 0, 0, 0, 0, 0},
      '{488566000, 23522000, 0, 0, 0, 0, 0},
      '{-338688000, 1512093000, 0, 0, 0, 0, 0},
      '{0, 0, 1, 1, 0, 0, 0}
   };

   initial begin
      hrd_pkg::req_type p;
      hrd_pkg::rsp_type t;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) begin
         p.lat_e7 = 31'(plan[i].lat);
         p.lon_e7 = 32'(plan[i].lon);
         p.start_route = plan[i].start;
         t.segment_mm = plan[i].seg[34:0];
         t.total_mm = plan[i].total[47:0];
         t.total_saturated = plan[i].sat;
         send_point(p, plan[i].typed, t);
      end
      write_radius(24'(MAX_RADIUS));
      random_run(200);
      write_radius(24'd1);
      random_run(150);
      write_radius(24'd0);
      random_run(100);
      repeat (6) begin
         write_radius(24'($urandom_range(1, MAX_RADIUS)));
         random_run(50);
      end
      write_radius(24'(MAX_RADIUS));
      idling = 1'b0;
      p = '0;
      p.start_route = 1'b1;
      send_point(p, 1'b0, '0);
      p.start_route = 1'b0;
      for (int i = 0; i < 330; i++) begin
         p.lon_e7 = (i % 2 == 0) ? 32'sd1800000000 : 32'sd0;
         send_point(p, 1'b0, '0);
      end
      write_radius(24'd6371000);
      random_run(50);
      req_valid <= 1'b0;
      while (pending_legs.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
